// ----- sv/min_tracking_stack_macros.svh -----
// Assertion macros for the min tracking stack.
// Included by modules that carry concurrent checks; expects aclk and aresetn in scope.
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define MTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mts_pkg.sv -----
// Shared types and constants for the min tracking stack.
// No dependencies; used by mts_cell and min_tracking_stack.
package mts_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    localparam cnt_t CNT_FULL = cnt_t'(DEPTH);

    // operation codes on tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // shift command broadcast to one row of cells
    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

endpackage

// ----- sv/mts_cell.sv -----
// One stack entry of a shifting cell row.
// Depends on mts_pkg for the data and shift command types.
module mts_cell (
    input  logic            aclk,
    input  mts_pkg::shift_t shift,
    input  mts_pkg::data_t  from_above,
    input  mts_pkg::data_t  from_below,
    output mts_pkg::data_t  data_out
);

    mts_pkg::data_t data_reg;

    // push moves entries away from the top, pop moves them toward it
    always_ff @(posedge aclk) begin
        if (shift.push) begin
            data_reg <= from_above;
        end else if (shift.pop) begin
            data_reg <= from_below;
        end
    end

    assign data_out = data_reg;

endmodule

// ----- sv/min_tracking_stack.sv -----
// Min tracking stack: a signed 32-bit LIFO of 64 entries that reports its top, its least
// held value, its depth and a status after every push or pop. Each input word carries one
// operation (s_tuser[0]: 0 push s_tdata, 1 pop) and returns exactly one result word in the
// cycle after on the m_ side. The block takes one word per cycle, sustained, as long as
// the result side keeps taking words: every operation moves a whole row of cells at once
// (the main row, and the minimum row when it changes), and the top and minimum always sit
// in cell zero, so one signed compare and one equality check per word set the pace. A
// result held back by m_tready stalls the input only while the result register is full
// and not being drained. Pushing onto a full stack returns status 1, popping an empty one
// returns status 2; neither changes anything. Top and minimum read as zero when empty.
// Depends on mts_pkg, mts_cell and min_tracking_stack_macros.svh.
`include "min_tracking_stack_macros.svh"

module min_tracking_stack (
    input  logic        aclk,
    input  logic        aresetn,
    // operation words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] func
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // [31:0] top_value, [63:32] min_value,
                                   // [70:64] depth, [72:71] status, [79:73] zero
);

    localparam int D = mts_pkg::DEPTH;

    // cell rows: index zero is the top of each stack
    mts_pkg::data_t  main_row [D];
    mts_pkg::data_t  min_row  [D];
    mts_pkg::shift_t main_shift;
    mts_pkg::shift_t min_shift;

    mts_pkg::cnt_t main_cnt_reg, main_cnt_next;
    mts_pkg::cnt_t min_cnt_reg,  min_cnt_next;

    logic           m_tvalid_reg;
    mts_pkg::data_t out_top_reg,   out_top_next;
    mts_pkg::data_t out_min_reg,   out_min_next;
    mts_pkg::cnt_t  out_depth_reg;
    logic [1:0]     out_status_reg, out_status_next;

    logic           s_accept;
    logic           is_push;
    logic           is_full;
    logic           is_empty;
    logic           push_ok;
    logic           pop_ok;
    logic           min_push;
    logic           min_pop;
    mts_pkg::data_t in_value;

    // take a new word whenever the result register is free or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign in_value = mts_pkg::data_t'(s_tdata);
    assign is_push  = (s_tuser[0] == mts_pkg::OP_PUSH);
    assign is_full  = (main_cnt_reg == mts_pkg::CNT_FULL);
    assign is_empty = (main_cnt_reg == '0);

    assign push_ok = s_accept && is_push && !is_full;
    assign pop_ok  = s_accept && !is_push && !is_empty;

    // track a new minimum on ties too, so a pop of a duplicate keeps the rest
    assign min_push = push_ok &&
                      ((min_cnt_reg == '0) || ($signed(in_value) <= $signed(min_row[0])));
    assign min_pop  = pop_ok && (min_cnt_reg != '0) && (min_row[0] == main_row[0]);

    assign main_shift = '{push: push_ok,  pop: pop_ok};
    assign min_shift  = '{push: min_push, pop: min_pop};

    // build both rows of cells; the top cell takes the pushed value,
    // the bottom cell takes zero on a pop
    for (genvar i = 0; i < D; i++) begin : g_cells
        mts_pkg::data_t main_above, main_below, min_above, min_below;

        if (i == 0) begin : g_top
            assign main_above = in_value;
            assign min_above  = in_value;
        end else begin : g_mid_above
            assign main_above = main_row[i-1];
            assign min_above  = min_row[i-1];
        end

        if (i == D - 1) begin : g_bottom
            assign main_below = '0;
            assign min_below  = '0;
        end else begin : g_mid_below
            assign main_below = main_row[i+1];
            assign min_below  = min_row[i+1];
        end

        mts_cell u_main_cell (
            .aclk       (aclk),
            .shift      (main_shift),
            .from_above (main_above),
            .from_below (main_below),
            .data_out   (main_row[i])
        );

        mts_cell u_min_cell (
            .aclk       (aclk),
            .shift      (min_shift),
            .from_above (min_above),
            .from_below (min_below),
            .data_out   (min_row[i])
        );
    end

    // counts and the result word, as they stand after this operation
    always_comb begin
        main_cnt_next   = main_cnt_reg;
        min_cnt_next    = min_cnt_reg;
        out_status_next = mts_pkg::ST_DONE;

        if (push_ok) begin
            main_cnt_next = main_cnt_reg + 1'b1;
        end else if (pop_ok) begin
            main_cnt_next = main_cnt_reg - 1'b1;
        end

        if (min_push) begin
            min_cnt_next = min_cnt_reg + 1'b1;
        end else if (min_pop) begin
            min_cnt_next = min_cnt_reg - 1'b1;
        end

        if (is_push && is_full) begin
            out_status_next = mts_pkg::ST_FULL;
        end else if (!is_push && is_empty) begin
            out_status_next = mts_pkg::ST_EMPTY;
        end

        // top after the operation: pushed value, next cell down, or held top
        if (push_ok) begin
            out_top_next = in_value;
        end else if (pop_ok) begin
            out_top_next = (main_cnt_reg > mts_pkg::cnt_t'(1)) ? main_row[1] : '0;
        end else begin
            out_top_next = is_empty ? '0 : main_row[0];
        end

        if (min_push) begin
            out_min_next = in_value;
        end else if (min_pop) begin
            out_min_next = (min_cnt_reg > mts_pkg::cnt_t'(1)) ? min_row[1] : '0;
        end else begin
            out_min_next = (min_cnt_reg == '0) ? '0 : min_row[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_cnt_reg <= '0;
            min_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            main_cnt_reg <= main_cnt_next;
            min_cnt_reg  <= min_cnt_next;
            if (s_accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // hold the result word until it is taken
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_top_reg    <= out_top_next;
            out_min_reg    <= out_min_next;
            out_depth_reg  <= main_cnt_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_status_reg, 7'(out_depth_reg),
                       32'(out_min_reg), 32'(out_top_reg)};

    // the minimum row never holds more entries than the main row
    `MTS_ASSERT_SAME(a_min_cnt_bound, 1'b1, min_cnt_reg <= main_cnt_reg, "min row deeper than main row")
    // a non-empty stack always has a tracked minimum
    `MTS_ASSERT_SAME(a_min_present, main_cnt_reg != '0, min_cnt_reg != '0, "stack holds entries but no minimum")
    // a refused push leaves the depth untouched
    `MTS_ASSERT_NEXT(a_full_hold, s_accept && is_push && is_full, $stable(main_cnt_reg), "refused push changed depth")
    // every accepted word produces a result word next cycle
    `MTS_ASSERT_NEXT(a_result_out, s_accept, m_tvalid, "accepted word produced no result")

endmodule
